// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the depth-first search block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GDFS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define GDFS_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define GDFS_ASSERT(lbl, clk, rstn, prop, msg)
`define GDFS_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ----- rtl/gdfs_pkg.sv -----
// Shared widths, operation and status codes for the depth-first search block.
// No dependencies.
package gdfs_pkg;

  localparam int MAX_VERTICES_DEF = 64;

  localparam int VW = 7;   // vertex number
  localparam int TW = 8;   // discover / finish time
  localparam int EW = 16;  // edge counter
  localparam int OW = 3;   // operation
  localparam int SW = 2;   // status

  localparam logic [OW-1:0] OP_EDGE   = 3'd0;
  localparam logic [OW-1:0] OP_ARC    = 3'd1;
  localparam logic [OW-1:0] OP_APPEND = 3'd2;
  localparam logic [OW-1:0] OP_RUN    = 3'd3;
  localparam logic [OW-1:0] OP_CLEAR  = 3'd4;

  localparam logic [SW-1:0] ST_OK    = 2'd0;
  localparam logic [SW-1:0] ST_RANGE = 2'd1;
  localparam logic [SW-1:0] ST_LEN   = 2'd2;
  localparam logic [SW-1:0] ST_FULL  = 2'd3;

  localparam logic [VW-1:0] VCOUNT_RST = 7'd64;

  // adjacency memory controls
  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } adj_ctrl_t;

endpackage

// ----- rtl/gdfs_if.sv -----
// Valid/ready channel interfaces for the depth-first search block.
// Depends on gdfs_pkg.
interface gdfs_in_if import gdfs_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [OW-1:0] op;
  logic [VW-1:0] vertex_u;
  logic [VW-1:0] vertex_v;

  modport source (output valid, op, vertex_u, vertex_v, input ready);
  modport sink (input valid, op, vertex_u, vertex_v, output ready);
endinterface

interface gdfs_out_if import gdfs_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [VW-1:0] vertex;
  logic [TW-1:0] discover_time;
  logic [TW-1:0] finish_time;
  logic [VW-1:0] parent_vertex;
  logic [EW-1:0] edge_total;
  logic [SW-1:0] status;
  logic          last;

  modport source (output valid, vertex, discover_time, finish_time, parent_vertex,
                  edge_total, status, last, input ready);
  modport sink (input valid, vertex, discover_time, finish_time, parent_vertex,
                edge_total, status, last, output ready);
endinterface

// ----- rtl/gdfs_adj_mem.sv -----
// Adjacency bit matrix: one row per vertex, registered read, row valid bits.
// Depends on gdfs_pkg; a row never written since reset or clear reads as zero.
module gdfs_adj_mem import gdfs_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  adj_ctrl_t                        ctrl_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]  raddr_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]  waddr_i,
  input  logic [MAX_VERTICES-1:0]          wdata_i,
  output logic [MAX_VERTICES-1:0]          rdata_o
);

  logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid_q;
  logic [MAX_VERTICES-1:0] rd_q;
  logic                    rv_q;

  // row valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (ctrl_i.clr) begin
      row_valid_q <= '0;
    end else if (ctrl_i.wr) begin
      row_valid_q[waddr_i] <= 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctrl_i.rd) begin
      rd_q <= mem[raddr_i];
      rv_q <= row_valid_q[raddr_i];
    end
  end

  assign rdata_o = rv_q ? rd_q : '0;

endmodule

// ----- rtl/graph_depth_first_search.sv -----
// Depth-first search block: edge, arc and order loads take one item each; an arc
// does a read-modify-write of the source row, an undirected edge also of the
// destination row, before the next item is taken. A run checks the order list one
// vertex at a time, then walks with one adjacency row read per step, then emits
// one result per vertex, waiting while the output stalls. Reset is asynchronous,
// active low: graph empty, order list empty, counters zero, vertex_count 64.
`include "assert_macros.svh"
module graph_depth_first_search import gdfs_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [VW-1:0] cfg_wdata_i,
  gdfs_in_if.sink       in_i,
  gdfs_out_if.source    out_o
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam logic [VW-1:0] MAXV_V = VW'(MAX_VERTICES);
  localparam logic [CW-1:0] MAXV_C = CW'(MAX_VERTICES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_E_RDU = 4'd1;
  localparam logic [3:0] S_E_WRU = 4'd2;
  localparam logic [3:0] S_E_RDV = 4'd3;
  localparam logic [3:0] S_E_WRV = 4'd4;
  localparam logic [3:0] S_CHK0  = 4'd5;
  localparam logic [3:0] S_CHK1  = 4'd6;
  localparam logic [3:0] S_ROOT0 = 4'd7;
  localparam logic [3:0] S_ROOT1 = 4'd8;
  localparam logic [3:0] S_DREAD = 4'd9;
  localparam logic [3:0] S_DEVAL = 4'd10;
  localparam logic [3:0] S_DPOP  = 4'd11;
  localparam logic [3:0] S_ORD0  = 4'd12;
  localparam logic [3:0] S_ORD1  = 4'd13;
  localparam logic [3:0] S_ORD2  = 4'd14;

  // control registers
  logic [3:0]              state_q, state_d;
  logic [VW-1:0]           vcount_q;
  logic [EW-1:0]           edge_cnt_q, edge_cnt_d;
  logic [CW-1:0]           order_len_q, order_len_d;
  logic [TW-1:0]           clock_q, clock_d;
  logic [MAX_VERTICES-1:0] white_q, white_d;
  logic [VW-1:0]           top_q, top_d;
  logic [CW-1:0]           sp_q, sp_d;
  logic [CW-1:0]           k_q, k_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic [AW-1:0]           eu_q, eu_d, ev_q, ev_d;
  logic                    e2_q, e2_d;

  // result register
  logic          out_valid_q, out_valid_d;
  logic [VW-1:0] out_vtx_q, out_par_q;
  logic [TW-1:0] out_disc_q, out_fin_q;
  logic [EW-1:0] out_edge_q;
  logic [SW-1:0] out_st_q;
  logic          out_last_q;

  logic          res_load;
  logic [VW-1:0] res_vtx, res_par;
  logic [TW-1:0] res_disc, res_fin;
  logic [SW-1:0] res_st;
  logic          res_last;

  // memories
  logic [VW-1:0]    order_mem [MAX_VERTICES];
  logic [VW-1:0]    stack_mem [MAX_VERTICES];
  logic [VW+TW-1:0] info_mem  [MAX_VERTICES];  // parent, discover
  logic [VW+TW-1:0] seq_mem   [MAX_VERTICES];  // vertex, finish
  logic [VW-1:0]    order_rd_q, stack_rd_q;
  logic [VW+TW-1:0] info_rd_q, seq_rd_q;

  logic             order_we, stack_we, info_we, seq_we;
  logic [AW-1:0]    order_waddr, info_waddr;
  logic [VW-1:0]    order_wdata;
  logic [VW+TW-1:0] info_wdata;
  logic [AW-1:0]    stack_raddr, seq_raddr, info_raddr;

  // adjacency
  adj_ctrl_t               adj_ctrl;
  logic [AW-1:0]           adj_raddr, adj_waddr;
  logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata, cand;
  logic [AW-1:0]           y_idx;

  logic [VW-1:0] n;
  logic          out_free, in_acc, u_ok, v_ok, ord_ok;
  logic          last_root;

  gdfs_adj_mem #(.MAX_VERTICES(MAX_VERTICES)) u_adj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (adj_ctrl),
    .raddr_i (adj_raddr),
    .waddr_i (adj_waddr),
    .wdata_i (adj_wdata),
    .rdata_o (adj_rdata)
  );

  // effective vertex count
  always_comb begin
    if (vcount_q == '0) begin
      n = VW'(1);
    end else if (vcount_q > MAXV_V) begin
      n = MAXV_V;
    end else begin
      n = vcount_q;
    end
  end

  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign in_acc     = in_i.valid && in_i.ready;
  assign u_ok       = (in_i.vertex_u != '0) && (in_i.vertex_u <= n);
  assign v_ok       = (in_i.vertex_v != '0) && (in_i.vertex_v <= n);
  assign ord_ok     = (order_rd_q != '0) && (order_rd_q <= n);
  assign last_root  = (VW'(idx_q) + VW'(1)) == n;

  // lowest white neighbor
  assign cand = adj_rdata & white_q;
  always_comb begin
    y_idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (cand[i]) y_idx = AW'(i);
    end
  end

  // memory read addresses
  assign stack_raddr = AW'(sp_q - CW'(2));
  assign seq_raddr   = AW'(k_q - idx_q - CW'(1));
  assign info_raddr  = AW'(seq_rd_q[VW+TW-1:TW] - VW'(1));

  // main sequencer
  always_comb begin
    state_d     = state_q;
    edge_cnt_d  = edge_cnt_q;
    order_len_d = order_len_q;
    clock_d     = clock_q;
    white_d     = white_q;
    top_d       = top_q;
    sp_d        = sp_q;
    k_d         = k_q;
    idx_d       = idx_q;
    eu_d        = eu_q;
    ev_d        = ev_q;
    e2_d        = e2_q;
    res_load    = 1'b0;
    res_vtx     = '0;
    res_par     = '0;
    res_disc    = '0;
    res_fin     = '0;
    res_st      = ST_OK;
    res_last    = 1'b1;
    order_we    = 1'b0;
    order_waddr = AW'(order_len_q);
    order_wdata = in_i.vertex_u;
    stack_we    = 1'b0;
    info_we     = 1'b0;
    info_waddr  = AW'(top_q - VW'(1));
    info_wdata  = '0;
    seq_we      = 1'b0;
    adj_ctrl    = '0;
    adj_raddr   = eu_q;
    adj_waddr   = eu_q;
    adj_wdata   = adj_rdata | ({{(MAX_VERTICES-1){1'b0}}, 1'b1} << ev_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          priority case (in_i.op)
            OP_EDGE, OP_ARC: begin
              res_load = 1'b1;
              if (u_ok && v_ok) begin
                if (edge_cnt_q != '1) edge_cnt_d = edge_cnt_q + EW'(1);
                eu_d    = AW'(in_i.vertex_u - VW'(1));
                ev_d    = AW'(in_i.vertex_v - VW'(1));
                e2_d    = (in_i.op == OP_EDGE);
                state_d = S_E_RDU;
              end else begin
                res_st = ST_RANGE;
              end
            end
            OP_APPEND: begin
              res_load = 1'b1;
              if (!u_ok) begin
                res_st = ST_RANGE;
              end else if (order_len_q >= MAXV_C) begin
                res_st = ST_FULL;
              end else begin
                order_we    = 1'b1;
                order_len_d = order_len_q + CW'(1);
              end
            end
            OP_RUN: begin
              if (VW'(order_len_q) != n) begin
                res_load = 1'b1;
                res_st   = ST_LEN;
              end else begin
                idx_d   = '0;
                state_d = S_CHK0;
              end
            end
            OP_CLEAR: begin
              res_load     = 1'b1;
              edge_cnt_d   = '0;
              order_len_d  = '0;
              clock_d      = '0;
              adj_ctrl.clr = 1'b1;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      // read-modify-write of the source row, then, for an undirected edge, the destination row
      S_E_RDU: begin
        adj_ctrl.rd = 1'b1;
        state_d     = S_E_WRU;
      end
      S_E_WRU: begin
        adj_ctrl.wr = 1'b1;
        state_d     = e2_q ? S_E_RDV : S_IDLE;
      end
      S_E_RDV: begin
        adj_ctrl.rd = 1'b1;
        adj_raddr   = ev_q;
        state_d     = S_E_WRV;
      end
      S_E_WRV: begin
        adj_ctrl.wr = 1'b1;
        adj_waddr   = ev_q;
        adj_wdata   = adj_rdata | ({{(MAX_VERTICES-1){1'b0}}, 1'b1} << eu_q);
        state_d     = S_IDLE;
      end
      // order list range check
      S_CHK0: begin
        state_d = S_CHK1;
      end
      S_CHK1: begin
        if (!ord_ok) begin
          if (out_free) begin
            res_load = 1'b1;
            res_st   = ST_RANGE;
            state_d  = S_IDLE;
          end
        end else if (last_root) begin
          for (int i = 0; i < MAX_VERTICES; i++) begin
            white_d[i] = VW'(i) < n;
          end
          clock_d = '0;
          idx_d   = '0;
          k_d     = '0;
          state_d = S_ROOT0;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = S_CHK0;
        end
      end
      // next root from the order list
      S_ROOT0: begin
        state_d = S_ROOT1;
      end
      S_ROOT1: begin
        if (white_q[AW'(order_rd_q - VW'(1))]) begin
          white_d[AW'(order_rd_q - VW'(1))] = 1'b0;
          clock_d    = clock_q + TW'(1);
          info_we    = 1'b1;
          info_waddr = AW'(order_rd_q - VW'(1));
          info_wdata = {VW'(0), clock_d};
          top_d      = order_rd_q;
          sp_d       = CW'(1);
          state_d    = S_DREAD;
        end else if (last_root) begin
          idx_d   = '0;
          state_d = S_ORD0;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = S_ROOT0;
        end
      end
      // walk: read the top vertex's row
      S_DREAD: begin
        adj_ctrl.rd = 1'b1;
        adj_raddr   = AW'(top_q - VW'(1));
        state_d     = S_DEVAL;
      end
      S_DEVAL: begin
        if ((cand != '0) && (sp_q < MAXV_C)) begin
          // discover the lowest white neighbor and push it
          white_d[y_idx] = 1'b0;
          clock_d    = clock_q + TW'(1);
          info_we    = 1'b1;
          info_waddr = y_idx;
          info_wdata = {top_q, clock_d};
          stack_we   = 1'b1;
          top_d      = VW'(y_idx) + VW'(1);
          sp_d       = sp_q + CW'(1);
          state_d    = S_DREAD;
        end else begin
          // finish the top vertex and pop
          clock_d = clock_q + TW'(1);
          seq_we  = 1'b1;
          k_d     = k_q + CW'(1);
          sp_d    = sp_q - CW'(1);
          if (sp_q > CW'(1)) begin
            state_d = S_DPOP;
          end else if (last_root) begin
            idx_d   = '0;
            state_d = S_ORD0;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = S_ROOT0;
          end
        end
      end
      S_DPOP: begin
        top_d   = stack_rd_q;
        state_d = S_DREAD;
      end
      // emit in decreasing finish order, rewrite the order list
      S_ORD0: begin
        state_d = S_ORD1;
      end
      S_ORD1: begin
        state_d = S_ORD2;
      end
      S_ORD2: begin
        if (out_free) begin
          res_load    = 1'b1;
          res_vtx     = seq_rd_q[VW+TW-1:TW];
          res_fin     = seq_rd_q[TW-1:0];
          res_par     = info_rd_q[VW+TW-1:TW];
          res_disc    = info_rd_q[TW-1:0];
          res_last    = (idx_q + CW'(1)) == k_q;
          order_we    = 1'b1;
          order_waddr = AW'(idx_q);
          order_wdata = seq_rd_q[VW+TW-1:TW];
          if (res_last) begin
            order_len_d = k_q;
            state_d     = S_IDLE;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = S_ORD0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vcount_q    <= VCOUNT_RST;
      edge_cnt_q  <= '0;
      order_len_q <= '0;
      clock_q     <= '0;
      white_q     <= '0;
      top_q       <= '0;
      sp_q        <= '0;
      k_q         <= '0;
      idx_q       <= '0;
      eu_q        <= '0;
      ev_q        <= '0;
      e2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      edge_cnt_q  <= edge_cnt_d;
      order_len_q <= order_len_d;
      clock_q     <= clock_d;
      white_q     <= white_d;
      top_q       <= top_d;
      sp_q        <= sp_d;
      k_q         <= k_d;
      idx_q       <= idx_d;
      eu_q        <= eu_d;
      ev_q        <= ev_d;
      e2_q        <= e2_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_d = res_load || (out_valid_q && !out_o.ready);

  // result payload
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_vtx_q  <= res_vtx;
      out_par_q  <= res_par;
      out_disc_q <= res_disc;
      out_fin_q  <= res_fin;
      out_edge_q <= edge_cnt_d;
      out_st_q   <= res_st;
      out_last_q <= res_last;
    end
  end

  // order list, stack and per-vertex tables
  always_ff @(posedge clk_i) begin
    if (order_we) order_mem[order_waddr] <= order_wdata;
    order_rd_q <= order_mem[AW'(idx_q)];
    if (stack_we) stack_mem[AW'(sp_q - CW'(1))] <= top_q;
    stack_rd_q <= stack_mem[stack_raddr];
    if (info_we) info_mem[info_waddr] <= info_wdata;
    info_rd_q <= info_mem[info_raddr];
    if (seq_we) seq_mem[AW'(k_q)] <= {top_q, clock_d};
    seq_rd_q <= seq_mem[seq_raddr];
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.vertex        = out_vtx_q;
  assign out_o.discover_time = out_disc_q;
  assign out_o.finish_time   = out_fin_q;
  assign out_o.parent_vertex = out_par_q;
  assign out_o.edge_total    = out_edge_q;
  assign out_o.status        = out_st_q;
  assign out_o.last          = out_last_q;

  // checks
  `GDFS_ASSERT(a_no_overwrite, clk_i, rst_ni, in_acc |-> (!out_valid_q || out_o.ready), "result overwritten")
  `GDFS_ASSERT_NEVER(a_stack_bound, clk_i, rst_ni, sp_q > MAXV_C, "stack beyond depth")
  `GDFS_ASSERT(a_time_order, clk_i, rst_ni, (out_valid_q && out_vtx_q != '0) |-> (out_disc_q < out_fin_q), "finish not after discover")

endmodule
